>>> hdl/tlnf_pkg.sv
// Shared constants, register codes and types of the text line number filter.
package tlnf_pkg;

   // Widths
   localparam int unsigned DATA_W         = 8;
   localparam int unsigned NUM_DIGITS_DEF = 6;
   localparam int unsigned CSR_ADDR_W     = 5;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned REG_IDX_W      = 3;
   localparam int unsigned TAIL_MAX       = 3;

   // Register indexes (byte address is 4 * index)
   localparam logic [REG_IDX_W-1:0] REG_NUMBER_NONBLANK  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_NUMBER_ALL       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SHOW_TABS        = 3'd5;

   // Character codes
   localparam logic [DATA_W-1:0] CHR_TAB     = 8'h09;
   localparam logic [DATA_W-1:0] CHR_LF      = 8'h0A;
   localparam logic [DATA_W-1:0] CHR_SPACE   = 8'h20;
   localparam logic [DATA_W-1:0] CHR_DOLLAR  = 8'h24;
   localparam logic [DATA_W-1:0] CHR_ZERO    = 8'h30;
   localparam logic [DATA_W-1:0] CHR_QMARK   = 8'h3F;
   localparam logic [DATA_W-1:0] CHR_I       = 8'h49;
   localparam logic [DATA_W-1:0] CHR_CARET   = 8'h5E;
   localparam logic [DATA_W-1:0] CHR_DEL     = 8'h7F;
   localparam logic [DATA_W-1:0] CTRL_LIMIT  = 8'h20;
   localparam logic [DATA_W-1:0] CTRL_OFFSET = 8'h40;

   // Option bits
   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_nonprinting;
      logic show_ends;
      logic show_tabs;
   } cfg_type;

   // What one input byte expands to: optional line number, then up to three bytes
   typedef struct packed {
      logic                             num_en;
      logic [1:0]                       tail_cnt;
      logic [TAIL_MAX-1:0][DATA_W-1:0]  tail;
   } render_type;

endpackage

>>> hdl/tlnf_req_if.sv
// Input channel: one raw text byte per beat.
interface tlnf_req_if import tlnf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;
   logic              end_of_file;

   modport source (output valid, data_byte, end_of_file, input ready);
   modport sink   (input valid, data_byte, end_of_file, output ready);
endinterface

>>> hdl/tlnf_rsp_if.sv
// Result channel: one formatted byte per beat.
interface tlnf_rsp_if import tlnf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_byte;
   logic              run_last;

   modport source (output valid, out_byte, run_last, input ready);
   modport sink   (input valid, out_byte, run_last, output ready);
endinterface

>>> hdl/tlnf_csr.sv
// APB-style option registers.
module tlnf_csr import tlnf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   wr_en;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   rd_bit;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign cfg     = cfg_ff;

   // Write decode, only bit 0 is kept
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_NUMBER_NONBLANK:  cfg_in.number_nonblank  = pwdata[0];
            REG_NUMBER_ALL:       cfg_in.number_all       = pwdata[0];
            REG_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = pwdata[0];
            REG_SHOW_NONPRINTING: cfg_in.show_nonprinting = pwdata[0];
            REG_SHOW_ENDS:        cfg_in.show_ends        = pwdata[0];
            REG_SHOW_TABS:        cfg_in.show_tabs        = pwdata[0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_NUMBER_NONBLANK:  rd_bit = cfg_ff.number_nonblank;
         REG_NUMBER_ALL:       rd_bit = cfg_ff.number_all;
         REG_SQUEEZE_BLANK:    rd_bit = cfg_ff.squeeze_blank;
         REG_SHOW_NONPRINTING: rd_bit = cfg_ff.show_nonprinting;
         REG_SHOW_ENDS:        rd_bit = cfg_ff.show_ends;
         REG_SHOW_TABS:        rd_bit = cfg_ff.show_tabs;
         default:              rd_bit = 1'b0;
      endcase
   end
   assign prdata = {{(CSR_DATA_W-1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/tlnf_format.sv
// Line state, BCD line counter and expansion of one byte into its output run.
module tlnf_format import tlnf_pkg::*; #(
   parameter int unsigned NUMBER_DIGITS = NUM_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfg_type                               cfg,
   input  logic [DATA_W-1:0]                     in_byte,
   input  logic                                  in_eof,
   input  logic                                  take,
   output render_type                            run,
   output logic [NUMBER_DIGITS-1:0][DATA_W-1:0]  num_text
);

   localparam int unsigned         COUNT_W   = 4 * NUMBER_DIGITS;
   localparam logic [COUNT_W-1:0]  COUNT_ONE = COUNT_W'(1);

   logic                at_line_start_ff, at_line_start_in;
   logic                prev_blank_ff,    prev_blank_in;
   logic [COUNT_W-1:0]  count_ff,         count_in;
   logic [COUNT_W-1:0]  count_inc;
   logic                blank, squeezed;
   logic                digits_ok;

   assign blank    = at_line_start_ff && (in_byte == CHR_LF);
   assign squeezed = blank && cfg.squeeze_blank && prev_blank_ff;

   // Expansion of the byte
   always_comb begin
      run = '0;
      if (blank) begin
         if (!squeezed) begin
            if (cfg.number_nonblank) begin
               if (cfg.show_ends) begin
                  run.tail[0]  = CHR_TAB;
                  run.tail[1]  = CHR_DOLLAR;
                  run.tail[2]  = CHR_LF;
                  run.tail_cnt = 2'd3;
               end else begin
                  run.tail[0]  = CHR_LF;
                  run.tail_cnt = 2'd1;
               end
            end else begin
               run.num_en = cfg.number_all;
               if (cfg.show_ends) begin
                  run.tail[0]  = CHR_DOLLAR;
                  run.tail[1]  = CHR_LF;
                  run.tail_cnt = 2'd2;
               end else begin
                  run.tail[0]  = CHR_LF;
                  run.tail_cnt = 2'd1;
               end
            end
         end
      end else begin
         run.num_en = at_line_start_ff && (cfg.number_nonblank || cfg.number_all);
         if (in_byte == CHR_LF) begin
            if (cfg.show_ends) begin
               run.tail[0]  = CHR_DOLLAR;
               run.tail[1]  = CHR_LF;
               run.tail_cnt = 2'd2;
            end else begin
               run.tail[0]  = CHR_LF;
               run.tail_cnt = 2'd1;
            end
         end else if (in_byte == CHR_TAB) begin
            if (cfg.show_tabs) begin
               run.tail[0]  = CHR_CARET;
               run.tail[1]  = CHR_I;
               run.tail_cnt = 2'd2;
            end else begin
               run.tail[0]  = in_byte;
               run.tail_cnt = 2'd1;
            end
         end else if (cfg.show_nonprinting && (in_byte < CTRL_LIMIT)) begin
            run.tail[0]  = CHR_CARET;
            run.tail[1]  = in_byte + CTRL_OFFSET;
            run.tail_cnt = 2'd2;
         end else if (cfg.show_nonprinting && (in_byte == CHR_DEL)) begin
            run.tail[0]  = CHR_CARET;
            run.tail[1]  = CHR_QMARK;
            run.tail_cnt = 2'd2;
         end else begin
            run.tail[0]  = in_byte;
            run.tail_cnt = 2'd1;
         end
      end
   end

   // Right-aligned digits, leading zeros blanked, units digit always shown
   always_comb begin
      logic       lead;
      logic [3:0] dig;
      lead     = 1'b1;
      num_text = '0;
      for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
         dig = count_ff[4*i +: 4];
         if (lead && (dig == 4'd0) && (i != 0)) begin
            num_text[NUMBER_DIGITS-1-i] = CHR_SPACE;
         end else begin
            lead = 1'b0;
            num_text[NUMBER_DIGITS-1-i] = CHR_ZERO | {4'h0, dig};
         end
      end
   end

   // BCD increment, wraps to zero past all nines
   always_comb begin
      logic       carry;
      logic [3:0] dig;
      carry     = 1'b1;
      count_inc = count_ff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         dig = count_ff[4*i +: 4];
         if (carry) begin
            count_inc[4*i +: 4] = (dig == 4'd9) ? 4'd0 : dig + 4'd1;
         end
         carry = carry && (dig == 4'd9);
      end
   end

   // Line state update when the byte leaves for the emitter
   always_comb begin
      at_line_start_in = at_line_start_ff;
      prev_blank_in    = prev_blank_ff;
      count_in         = count_ff;
      if (take) begin
         if (blank) begin
            if (!squeezed) begin
               prev_blank_in = 1'b1;
            end
         end else begin
            if (at_line_start_ff) begin
               prev_blank_in = 1'b0;
            end
            at_line_start_in = (in_byte == CHR_LF);
         end
         if (run.num_en) begin
            count_in = count_inc;
         end
         if (in_eof) begin
            at_line_start_in = 1'b1;
            prev_blank_in    = 1'b0;
            count_in         = COUNT_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         prev_blank_ff    <= 1'b0;
         count_ff         <= COUNT_ONE;
      end else begin
         at_line_start_ff <= at_line_start_in;
         prev_blank_ff    <= prev_blank_in;
         count_ff         <= count_in;
      end
   end

   // Every counter digit stays a decimal digit
   always_comb begin
      digits_ok = 1'b1;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         if (count_ff[4*i +: 4] > 4'd9) begin
            digits_ok = 1'b0;
         end
      end
   end

   a_bcd_digits: assert property (@(posedge clock) disable iff (reset) digits_ok)
      else $error("line counter holds a non-decimal digit");

   a_eof_restart: assert property (@(posedge clock) disable iff (reset)
      take && in_eof |=> at_line_start_ff && !prev_blank_ff && (count_ff == COUNT_ONE))
      else $error("end of file did not restart the line state");

endmodule

>>> hdl/tlnf_emit.sv
// Output shift register: holds one run and sends it a byte per beat.
module tlnf_emit import tlnf_pkg::*; #(
   parameter int unsigned NUMBER_DIGITS = NUM_DIGITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  render_type                            run,
   input  logic [NUMBER_DIGITS-1:0][DATA_W-1:0]  num_text,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [DATA_W-1:0]                     out_byte,
   output logic                                  run_last,
   output logic                                  free
);

   localparam int unsigned MAX_RUN = NUMBER_DIGITS + 1 + TAIL_MAX;
   localparam int unsigned CNT_W   = $clog2(MAX_RUN + 1);

   logic [DATA_W-1:0] byte_ff [MAX_RUN];
   logic [DATA_W-1:0] byte_in [MAX_RUN];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              sent;

   assign rsp_valid = (cnt_ff != '0);
   assign out_byte  = byte_ff[0];
   assign run_last  = (cnt_ff == CNT_W'(1));
   assign sent      = rsp_valid && rsp_ready;
   assign free      = (cnt_ff == '0) || (run_last && rsp_ready);

   // Load a new run or shift the current one along
   always_comb begin
      byte_in = byte_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         if (run.num_en) begin
            for (int k = 0; k < NUMBER_DIGITS; k++) begin
               byte_in[k] = num_text[k];
            end
            byte_in[NUMBER_DIGITS] = CHR_TAB;
            for (int j = 0; j < TAIL_MAX; j++) begin
               byte_in[NUMBER_DIGITS+1+j] = run.tail[j];
            end
            cnt_in = CNT_W'(NUMBER_DIGITS + 1) + CNT_W'(run.tail_cnt);
         end else begin
            for (int j = 0; j < TAIL_MAX; j++) begin
               byte_in[j] = run.tail[j];
            end
            cnt_in = CNT_W'(run.tail_cnt);
         end
      end else if (sent) begin
         for (int k = 0; k < MAX_RUN - 1; k++) begin
            byte_in[k] = byte_ff[k+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff > CNT_W'(1)) |-> !load)
      else $error("new run loaded over an unfinished one");

endmodule

>>> hdl/text_line_number_filter.sv
// Text line number filter: cat-style numbering, blank squeezing, line-end
// marks and caret display over a byte stream. Each accepted byte yields a
// run of zero to NUMBER_DIGITS+3 result bytes; the run is held in an output
// shift register that sends one byte per cycle while rsp_bus.ready is high,
// and plain bytes pass at one byte per cycle while it stays high, each held
// first in the input register and then in the shift register. The next byte
// is taken in as the last byte of the current run is accepted.
// Numbering restarts at 1 after each byte flagged end_of_file, and the
// count wraps to 0 after all nines. Options sit at byte addresses 0 to 20
// and are to be changed only while the block is idle.
module text_line_number_filter import tlnf_pkg::*; #(
   parameter int unsigned NUMBER_DIGITS = NUM_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tlnf_req_if.sink              req_bus,
   tlnf_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type                                cfg;
   render_type                             run;
   logic [NUMBER_DIGITS-1:0][DATA_W-1:0]   num_text;
   logic                                   in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]                      in_byte_ff, in_byte_in;
   logic                                   in_eof_ff,  in_eof_in;
   logic                                   emit_free;
   logic                                   take;
   logic                                   req_beat;

   // Input register
   assign take          = in_valid_ff && emit_free;
   assign req_bus.ready = !in_valid_ff || take;
   assign req_beat      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eof_in   = in_eof_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.data_byte;
         in_eof_in   = req_bus.end_of_file;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eof_ff  <= in_eof_in;
   end

   tlnf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tlnf_format #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_format (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_byte  (in_byte_ff),
      .in_eof   (in_eof_ff),
      .take     (take),
      .run      (run),
      .num_text (num_text)
   );

   tlnf_emit #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .run       (run),
      .num_text  (num_text),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .out_byte  (rsp_bus.out_byte),
      .run_last  (rsp_bus.run_last),
      .free      (emit_free)
   );

   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !take |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eof_ff))
      else $error("pending input byte lost before formatting");

endmodule

>>> bench/text_line_number_filter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the text line number filter: directed cases, then random files.
module text_line_number_filter_tb;
   import tlnf_pkg::*;

   localparam int unsigned DIGITS      = NUM_DIGITS_DEF;
   localparam int unsigned SETTLE_WAIT = 16;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned PHASE_BEATS = 45;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              run_last;
   } text_beat_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   tlnf_req_if req_if ();
   tlnf_rsp_if rsp_if ();

   text_line_number_filter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of options and formatter state
   cfg_type                  opts       = '0;
   logic                     line_start = 1'b1;
   logic                     prev_blank = 1'b0;
   logic [4*DIGITS-1:0]      line_bcd   = (4*DIGITS)'(1);
   logic [DATA_W-1:0]        run_bytes[$];
   text_beat_type            expected_beats[$];

   int unsigned failures   = 0;
   int unsigned cycles     = 0;
   int unsigned sent_beats = 0;
   bit          tx_gaps    = 1'b1;
   bit          rx_stalls  = 1'b1;
   int unsigned stall_left = 0;

   always #5 clock = ~clock;

   // Run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Line number: right-aligned digits with leading blanks, then a tab
   function automatic void emit_line_number();
      logic [3:0] digit;
      bit         leading;
      bit         carry;
      leading = 1'b1;
      for (int i = DIGITS - 1; i >= 0; i--) begin
         digit = line_bcd[4*i +: 4];
         if (digit > 4'd9) digit = 4'd9;
         if (leading && digit == 4'd0 && i != 0) begin
            run_bytes.push_back(CHR_SPACE);
         end else begin
            leading = 1'b0;
            run_bytes.push_back(CHR_ZERO + DATA_W'(digit));
         end
      end
      run_bytes.push_back(CHR_TAB);
      // BCD increment, wrapping to zero past all nines
      carry = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (carry) begin
            if (line_bcd[4*i +: 4] < 4'd9) begin
               line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
               carry = 1'b0;
            end else begin
               line_bcd[4*i +: 4] = 4'd0;
            end
         end
      end
   endfunction

   function automatic void emit_line_end();
      if (opts.show_ends) run_bytes.push_back(CHR_DOLLAR);
      run_bytes.push_back(CHR_LF);
   endfunction

   // Works out the bytes one input beat turns into and queues them
   function automatic void format_byte(input logic [DATA_W-1:0] c, input logic eof);
      text_beat_type beat;
      run_bytes.delete();
      if (line_start && c == CHR_LF) begin
         if (!(opts.squeeze_blank && prev_blank)) begin
            prev_blank = 1'b1;
            if (opts.number_nonblank) begin
               if (opts.show_ends) begin
                  run_bytes.push_back(CHR_TAB);
                  run_bytes.push_back(CHR_DOLLAR);
               end
               run_bytes.push_back(CHR_LF);
            end else begin
               if (opts.number_all) emit_line_number();
               emit_line_end();
            end
         end
      end else begin
         if (line_start) begin
            prev_blank = 1'b0;
            if (opts.number_nonblank || opts.number_all) emit_line_number();
         end
         if (c == CHR_LF) begin
            emit_line_end();
            line_start = 1'b1;
         end else begin
            if (c == CHR_TAB && opts.show_tabs) begin
               run_bytes.push_back(CHR_CARET);
               run_bytes.push_back(CHR_I);
            end else if (c != CHR_TAB && opts.show_nonprinting && c < CTRL_LIMIT) begin
               run_bytes.push_back(CHR_CARET);
               run_bytes.push_back(c + CTRL_OFFSET);
            end else if (opts.show_nonprinting && c == CHR_DEL) begin
               run_bytes.push_back(CHR_CARET);
               run_bytes.push_back(CHR_QMARK);
            end else begin
               run_bytes.push_back(c);
            end
            line_start = 1'b0;
         end
      end
      if (eof) begin
         line_start = 1'b1;
         prev_blank = 1'b0;
         line_bcd   = (4*DIGITS)'(1);
      end
      foreach (run_bytes[i]) begin
         beat.out_byte = run_bytes[i];
         beat.run_last = (i == run_bytes.size() - 1);
         expected_beats.push_back(beat);
      end
   endfunction

   // Result side: random back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= pick_gap();
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Result checker: each beat against the oldest expectation
   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got byte %h last %b",
                     $time, rsp_if.out_byte, rsp_if.run_last);
            failures++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_if.out_byte !== want.out_byte) begin
               $display("%0t: out_byte mismatch, expected %h, got %h",
                        $time, want.out_byte, rsp_if.out_byte);
               failures++;
            end
            if (rsp_if.run_last !== want.run_last) begin
               $display("%0t: run_last mismatch, expected %b, got %b",
                        $time, want.run_last, rsp_if.run_last);
               failures++;
            end
         end
      end
   end

   // Sends one input beat and predicts its results on acceptance
   task automatic send_byte(input logic [DATA_W-1:0] c, input logic eof);
      int unsigned gap;
      gap = tx_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= c;
      req_if.end_of_file <= eof;
      do @(posedge clock); while (!req_if.ready);
      format_byte(c, eof);
      sent_beats++;
   endtask

   // Waits until every expected beat has arrived and the block has gone quiet
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // APB write with random upper bits, then read back
   task automatic write_option(input logic [REG_IDX_W-1:0] idx, input logic v);
      logic [CSR_DATA_W-1:0] word;
      word    = $urandom;
      word[0] = v;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_NUMBER_NONBLANK:  opts.number_nonblank  = v;
         REG_NUMBER_ALL:       opts.number_all       = v;
         REG_SQUEEZE_BLANK:    opts.squeeze_blank    = v;
         REG_SHOW_NONPRINTING: opts.show_nonprinting = v;
         REG_SHOW_ENDS:        opts.show_ends        = v;
         REG_SHOW_TABS:        opts.show_tabs        = v;
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== v) begin
         $display("%0t: readback of register %0d, expected %b, got %b",
                  $time, idx, v, prdata[0]);
         failures++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_options(input cfg_type o);
      drain_results();
      write_option(REG_NUMBER_NONBLANK,  o.number_nonblank);
      write_option(REG_NUMBER_ALL,       o.number_all);
      write_option(REG_SQUEEZE_BLANK,    o.squeeze_blank);
      write_option(REG_SHOW_NONPRINTING, o.show_nonprinting);
      write_option(REG_SHOW_ENDS,        o.show_ends);
      write_option(REG_SHOW_TABS,        o.show_tabs);
   endtask

   // Text-like byte: printable, tab, control, DEL or high byte, never LF
   function automatic logic [DATA_W-1:0] pick_text_byte();
      int unsigned r;
      logic [DATA_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 50) return DATA_W'($urandom_range(32, 126));
      if (r < 60) return CHR_TAB;
      if (r < 75) begin
         c = DATA_W'($urandom_range(0, 31));
         return (c == CHR_LF) ? 8'h0B : c;
      end
      if (r < 80) return CHR_DEL;
      return DATA_W'($urandom_range(128, 255));
   endfunction

   // Plain bytes and byte extremes, all options off
   task automatic test_plain_text();
      set_options('0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHR_DEL, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(CHR_TAB, 1'b0);
      send_byte(CHR_LF, 1'b1);
   endtask

   // Caret display of controls, tab and DEL; high bytes unchanged; '$' at line end
   task automatic test_caret_notation();
      cfg_type o;
      o = '0;
      o.show_nonprinting = 1'b1;
      o.show_tabs        = 1'b1;
      o.show_ends        = 1'b1;
      set_options(o);
      send_byte(8'h00, 1'b0);
      send_byte(8'h1F, 1'b0);
      send_byte(CHR_TAB, 1'b0);
      send_byte(CHR_DEL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHR_LF, 1'b1);
   endtask

   // Non-blank numbering overriding number-all, squeezing, reset of both at end of file
   task automatic test_blank_lines();
      cfg_type o;
      o = '1;
      o.show_nonprinting = 1'b0;
      o.show_tabs        = 1'b0;
      set_options(o);
      send_byte(CHR_LF, 1'b0);
      send_byte(CHR_LF, 1'b0);
      send_byte(CHR_LF, 1'b0);
      send_byte(8'h78, 1'b0);
      send_byte(CHR_LF, 1'b0);
      send_byte(CHR_LF, 1'b0);
      send_byte(CHR_LF, 1'b1);
      send_byte(CHR_LF, 1'b0);
   endtask

   // Numbering of every line; file ending without newline restarts the count
   task automatic test_number_all();
      cfg_type o;
      o = '0;
      o.number_all = 1'b1;
      set_options(o);
      send_byte(CHR_LF, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      send_byte(8'h63, 1'b0);
      send_byte(CHR_LF, 1'b1);
   endtask

   // Long file so the count carries into the tens and hundreds
   task automatic test_count_carry();
      cfg_type o;
      o = '0;
      o.number_all = 1'b1;
      set_options(o);
      repeat (104) send_byte(CHR_LF, 1'b0);
      send_byte(8'h71, 1'b1);
   endtask

   // One file of short lines; the last may end without a newline
   task automatic send_random_file();
      int unsigned lines;
      int unsigned len;
      bit          open_end;
      lines = $urandom_range(1, 6);
      for (int unsigned l = 0; l < lines; l++) begin
         len      = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         open_end = (l == lines - 1) && len > 0 && $urandom_range(0, 3) == 0;
         for (int unsigned k = 0; k < len; k++)
            send_byte(pick_text_byte(), open_end && k == len - 1);
         if (!open_end) send_byte(CHR_LF, l == lines - 1);
      end
   endtask

   // Random phases: all options on, all off, then random settings
   task automatic test_random_files();
      cfg_type     o;
      int unsigned phase_end;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 0)      o = '1;
         else if (phase == 1) o = '0;
         else                 o = cfg_type'(6'($urandom_range(0, 63)));
         set_options(o);
         tx_gaps   = (phase != 2) && (phase != 5);
         rx_stalls = (phase != 2);
         phase_end = sent_beats + PHASE_BEATS;
         while (sent_beats < phase_end) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: raw bytes with stray end-of-file flags
               repeat ($urandom_range(1, 4))
                  send_byte(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
               send_random_file();
            end
         end
      end
      tx_gaps   = 1'b1;
      rx_stalls = 1'b1;
   endtask

   initial begin
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_if.valid       <= 1'b0;
      req_if.data_byte   <= '0;
      req_if.end_of_file <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_plain_text();
      test_caret_notation();
      test_blank_lines();
      test_number_all();
      test_count_carry();
      test_random_files();
      drain_results();

      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
